### hw/rtl/brd_pkg.sv
// Shared types, codes and constants for the block repeat decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package brd_pkg;

  localparam int MAX_BLOCK_DEF = 8;
  localparam int CHAR_W        = 8;
  localparam int CFG_W         = 4;
  localparam int COUNT_W       = 4;
  localparam int STATUS_W      = 2;
  localparam int REPS_W        = 4;

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_ONE  = 8'h31;
  localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ILLEGAL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TRUNC   = 2'd2;

  localparam logic [CFG_W-1:0] BLOCK_LENGTH_RST = 4'd1;

  typedef enum logic [2:0] {
    MODE_LITERAL,
    MODE_CAPTURE,
    MODE_FLUSH_FULL,
    MODE_FLUSH_END,
    MODE_HALTED
  } mode_t;

  // Controller to datapath
  typedef struct packed {
    logic start_block;
    logic store_byte;
    logic emit_literal;
    logic emit_illegal;
    logic flush;
    logic flush_end;
  } brd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_zero;
    logic is_digit;
    logic is_legal;
    logic full_next;
    logic burst_busy;
    logic block_err;
  } brd_stat_t;

  // Letters, punctuation and space characters of the C locale
  function automatic logic legal_byte(input logic [CHAR_W-1:0] c);
    logic ok;
    ok = ((c >= 8'd65)  && (c <= 8'd90))  || ((c >= 8'd97)  && (c <= 8'd122)) ||
         ((c >= 8'd33)  && (c <= 8'd47))  || ((c >= 8'd58)  && (c <= 8'd64))  ||
         ((c >= 8'd91)  && (c <= 8'd96))  || ((c >= 8'd123) && (c <= 8'd126)) ||
         ((c >= 8'd9)   && (c <= 8'd13))  || (c == 8'd32);
    return ok;
  endfunction

endpackage

### hw/rtl/brd_ctrl.sv
// Mode controller of the block repeat decoder.
// Depends on brd_pkg; drives brd_dp through brd_cmd_t and reads brd_stat_t.
`timescale 1ns / 1ps

module brd_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             end_of_text,
  output logic             in_ready,
  input  brd_pkg::brd_stat_t stat,
  output brd_pkg::brd_cmd_t  cmd
);
  import brd_pkg::*;

  mode_t state;
  mode_t state_next;
  logic  accept;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MODE_LITERAL;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      MODE_LITERAL: begin
        if (accept) begin
          if (end_of_text || stat.is_zero) begin
            state_next = MODE_HALTED;
          end else if (stat.is_digit) begin
            state_next = MODE_CAPTURE;
          end else if (!stat.is_legal) begin
            state_next = MODE_HALTED;
          end
        end
      end
      MODE_CAPTURE: begin
        if (accept) begin
          if (end_of_text) begin
            state_next = MODE_FLUSH_END;
          end else if (stat.full_next) begin
            state_next = MODE_FLUSH_FULL;
          end
        end
      end
      MODE_FLUSH_FULL: state_next = stat.block_err ? MODE_HALTED : MODE_LITERAL;
      MODE_FLUSH_END:  state_next = MODE_HALTED;
      MODE_HALTED:     state_next = MODE_HALTED;
      default:         state_next = MODE_HALTED;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      MODE_LITERAL: begin
        in_ready = !stat.burst_busy;
        if (accept && !end_of_text && !stat.is_zero) begin
          cmd.start_block  = stat.is_digit;
          cmd.emit_literal = !stat.is_digit && stat.is_legal;
          cmd.emit_illegal = !stat.is_digit && !stat.is_legal;
        end
      end
      MODE_CAPTURE: begin
        in_ready       = !stat.burst_busy;
        cmd.store_byte = accept && !end_of_text;
      end
      MODE_FLUSH_FULL: cmd.flush = 1'b1;
      MODE_FLUSH_END: begin
        cmd.flush     = 1'b1;
        cmd.flush_end = 1'b1;
      end
      MODE_HALTED: in_ready = 1'b1;
      default:     in_ready = 1'b0;
    endcase
  end

endmodule

### hw/rtl/brd_dp.sv
// Datapath of the block repeat decoder: length register, block store,
// burst register and output register. Depends on brd_pkg; driven by brd_ctrl.
`timescale 1ns / 1ps

module brd_dp #(
  parameter int MAX_BLOCK = brd_pkg::MAX_BLOCK_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [brd_pkg::CFG_W-1:0]           cfg_wdata,
  input  logic [brd_pkg::CHAR_W-1:0]          char_in,
  input  brd_pkg::brd_cmd_t                   cmd,
  output brd_pkg::brd_stat_t                  stat,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [8*MAX_BLOCK-1:0]              block_bytes,
  output logic [brd_pkg::COUNT_W-1:0]         byte_count,
  output logic [brd_pkg::STATUS_W-1:0]        status,
  output logic                                last_result
);
  import brd_pkg::*;

  localparam int CntW = $clog2(MAX_BLOCK + 1);
  localparam int IdxW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
  localparam int BytesW = 8 * MAX_BLOCK;

  logic [CFG_W-1:0]    block_length;
  logic [CntW-1:0]     fill_count;
  logic [REPS_W-1:0]   repeat_count;
  logic [CHAR_W-1:0]   block_store [MAX_BLOCK];
  logic [MAX_BLOCK-1:0] legal_store;

  logic [BytesW-1:0]   burst_bytes;
  logic [CntW-1:0]     burst_count;
  logic [STATUS_W-1:0] burst_status;
  logic [REPS_W-1:0]   burst_left;

  logic [CFG_W-1:0]    len_clamp;
  logic [CntW-1:0]     len_eff;
  logic                fill_room;
  logic [CntW-1:0]     fill_next;
  logic [CntW-1:0]     flush_len;
  logic [MAX_BLOCK-1:0] bad;
  logic [CntW-1:0]     first_bad;
  logic [CntW-1:0]     flush_count;
  logic [BytesW-1:0]   flush_bytes;
  logic [BytesW-1:0]   lit_bytes;
  logic                out_load;

  // Length 0 acts as 1, anything above the store depth as the depth
  always_comb begin
    if (block_length == '0) begin
      len_clamp = CFG_W'(1);
    end else if (block_length > CFG_W'(MAX_BLOCK)) begin
      len_clamp = CFG_W'(MAX_BLOCK);
    end else begin
      len_clamp = block_length;
    end
  end
  assign len_eff   = CntW'(len_clamp);
  assign fill_room = fill_count < len_eff;
  assign fill_next = fill_room ? fill_count + CntW'(1) : fill_count;
  assign flush_len = fill_room ? fill_count : len_eff;

  // Find the first illegal byte inside the flushed length
  always_comb begin
    first_bad = '0;
    for (int i = MAX_BLOCK - 1; i >= 0; i--) begin
      bad[i] = (CntW'(i) < flush_len) && !legal_store[i];
      if (bad[i]) begin
        first_bad = CntW'(i);
      end
    end
  end

  assign flush_count = (|bad) ? first_bad : flush_len;

  always_comb begin
    for (int i = 0; i < MAX_BLOCK; i++) begin
      flush_bytes[8*i +: 8] = (CntW'(i) < flush_count) ? block_store[i] : '0;
    end
    lit_bytes      = '0;
    lit_bytes[7:0] = char_in;
  end

  assign stat.is_zero    = char_in == CHAR_ZERO;
  assign stat.is_digit   = (char_in >= CHAR_ONE) && (char_in <= CHAR_NINE);
  assign stat.is_legal   = legal_byte(char_in);
  assign stat.full_next  = fill_next >= len_eff;
  assign stat.burst_busy = burst_left != '0;
  assign stat.block_err  = |bad;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_length <= BLOCK_LENGTH_RST;
    end else if (cfg_we) begin
      block_length <= cfg_wdata;
    end
  end

  // Capture counters
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count   <= '0;
      repeat_count <= '0;
    end else begin
      if (cmd.start_block) begin
        repeat_count <= REPS_W'(char_in[3:0]);
        fill_count   <= '0;
      end else if (cmd.store_byte) begin
        fill_count <= fill_next;
      end else if (cmd.flush) begin
        fill_count <= '0;
      end
    end
  end

  // Block store, written at the fill position
  always_ff @(posedge clk) begin
    if (cmd.store_byte && fill_room) begin
      block_store[fill_count[IdxW-1:0]] <= char_in;
      legal_store[fill_count[IdxW-1:0]] <= legal_byte(char_in);
    end
  end

  // Burst register: one descriptor, repeated burst_left times
  always_ff @(posedge clk) begin
    if (rst) begin
      burst_left <= '0;
    end else if (cmd.emit_literal || cmd.emit_illegal) begin
      burst_left <= REPS_W'(1);
    end else if (cmd.flush) begin
      if (|bad || (cmd.flush_end && flush_len == '0)) begin
        burst_left <= REPS_W'(1);
      end else begin
        burst_left <= repeat_count;
      end
    end else if (out_load) begin
      burst_left <= burst_left - REPS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_literal) begin
      burst_bytes  <= lit_bytes;
      burst_count  <= CntW'(1);
      burst_status <= ST_OK;
    end else if (cmd.emit_illegal) begin
      burst_bytes  <= '0;
      burst_count  <= '0;
      burst_status <= ST_ILLEGAL;
    end else if (cmd.flush) begin
      burst_bytes  <= flush_bytes;
      burst_count  <= flush_count;
      if (|bad) begin
        burst_status <= ST_ILLEGAL;
      end else if (cmd.flush_end) begin
        burst_status <= ST_TRUNC;
      end else begin
        burst_status <= ST_OK;
      end
    end
  end

  // Output register; status applies to the final repetition only
  assign out_load = stat.burst_busy && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      block_bytes <= burst_bytes;
      byte_count  <= COUNT_W'(burst_count);
      last_result <= burst_left == REPS_W'(1);
      status      <= (burst_left == REPS_W'(1)) ? burst_status : ST_OK;
    end
  end

endmodule

### hw/rtl/block_repeat_decoder_top.sv
// Block repeat decoder, top level.
// Depends on brd_pkg, brd_ctrl and brd_dp.
`timescale 1ns / 1ps

// Decodes a byte stream into packed results. In literal mode a letter,
// punctuation or space byte comes out as a one-byte result; a digit 1..9
// captures the next block_length bytes and replays them that many times,
// one result per repetition; '0' or end of text stops decoding; any other
// byte gives an illegal-character result and the decoder halts until rst.
// Timing: a captured byte is taken as soon as it is offered; a literal byte
// holds the input while its result moves into the output register. The byte
// that completes a block, or end of text during capture, adds a flush state in
// which the input is not ready. Results leave at one per cycle from an output
// register while out_ready allows; in literal and capture mode a new input
// transaction is taken once the burst register has handed its last repetition
// to the output register, so a digit-n block holds the input after the flush
// state while its n repetitions drain, longer when out_ready stalls.
// Configuration (block_length) is written with cfg_we/cfg_wdata, no wait.

module block_repeat_decoder_top #(
  parameter int MAX_BLOCK = brd_pkg::MAX_BLOCK_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration
  input  logic                          cfg_we,
  input  logic [brd_pkg::CFG_W-1:0]     cfg_wdata,
  // Input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [brd_pkg::CHAR_W-1:0]    char_in,
  input  logic                          end_of_text,
  // Output channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [8*MAX_BLOCK-1:0]        block_bytes,
  output logic [brd_pkg::COUNT_W-1:0]   byte_count,
  output logic [brd_pkg::STATUS_W-1:0]  status,
  output logic                          last_result
);
  import brd_pkg::*;

  brd_cmd_t  cmd;
  brd_stat_t stat;

  // Mode sequencing: literal, capture, flush, halted
  brd_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .end_of_text (end_of_text),
    .in_ready    (in_ready),
    .stat        (stat),
    .cmd         (cmd)
  );

  // Store, repeat burst and output register
  brd_dp #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .char_in     (char_in),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .block_bytes (block_bytes),
    .byte_count  (byte_count),
    .status      (status),
    .last_result (last_result)
  );

endmodule

### hw/rtl/brd_checker.sv
// Port-level checks for the block repeat decoder, bound to the top level.
// Depends on brd_pkg and block_repeat_decoder_top.
`timescale 1ns / 1ps

module brd_sva #(
  parameter int MAX_BLOCK = brd_pkg::MAX_BLOCK_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [8*MAX_BLOCK-1:0]        block_bytes,
  input logic [brd_pkg::COUNT_W-1:0]   byte_count,
  input logic [brd_pkg::STATUS_W-1:0]  status,
  input logic                          last_result
);
  import brd_pkg::*;

  // Hold a stalled output transaction
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(block_bytes) &&
      $stable(byte_count) && $stable(status) && $stable(last_result))
    else $error("output transaction changed while stalled");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> byte_count <= COUNT_W'(MAX_BLOCK))
    else $error("byte_count beyond block size");

  // Error and truncation results close the burst
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> last_result)
    else $error("non-ok status on a non-final result");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_count == '0 |-> block_bytes == '0)
    else $error("empty result carries data");

endmodule

bind block_repeat_decoder_top brd_sva #(
  .MAX_BLOCK (MAX_BLOCK)
) u_brd_sva (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .block_bytes (block_bytes),
  .byte_count  (byte_count),
  .status      (status),
  .last_result (last_result)
);
